// File: src/spc_pkg.sv
package spc_pkg;

  // Fixed field widths and fixed-point formats.
  localparam int NORMAL_W   = 16;
  localparam int COORD_FRAC = 16;
  localparam int EPS_W      = 16;

  // Guard bits of a three-term dot product over a normal and a coordinate difference.
  localparam int DOT_GUARD = 19;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;

  // Value of zero_epsilon after reset.
  localparam logic [EPS_W-1:0] EPS_RESET = 16'd66;

  // Byte address of the zero_epsilon register.
  localparam logic [1:0] ADDR_ZERO_EPSILON = 2'd0;

  // Result classes.
  typedef enum logic [1:0] {
    CLS_COPLANAR = 2'd0,
    CLS_PARALLEL = 2'd1,
    CLS_ON_SEG   = 2'd2,
    CLS_OFF_SEG  = 2'd3
  } seg_class_t;

  // Width of one queued item; it must match item_t in the front and the back.
  function automatic int item_bits(input int coord_w);
    return 11 * coord_w + 4 + 2 * DOT_GUARD + 3 * NORMAL_W + 3;
  endfunction

endpackage

// File: src/spc_in_if.sv
interface spc_in_if #(
  parameter int COORD_WIDTH = 32
);
  logic                                valid;
  logic                                ready;
  logic signed [spc_pkg::NORMAL_W-1:0] normal_x;
  logic signed [spc_pkg::NORMAL_W-1:0] normal_y;
  logic signed [spc_pkg::NORMAL_W-1:0] normal_z;
  logic signed [COORD_WIDTH-1:0]       plane_point_x;
  logic signed [COORD_WIDTH-1:0]       plane_point_y;
  logic signed [COORD_WIDTH-1:0]       plane_point_z;
  logic signed [COORD_WIDTH-1:0]       start_x;
  logic signed [COORD_WIDTH-1:0]       start_y;
  logic signed [COORD_WIDTH-1:0]       start_z;
  logic signed [COORD_WIDTH-1:0]       end_x;
  logic signed [COORD_WIDTH-1:0]       end_y;
  logic signed [COORD_WIDTH-1:0]       end_z;

  modport source (
    output valid, normal_x, normal_y, normal_z,
    output plane_point_x, plane_point_y, plane_point_z,
    output start_x, start_y, start_z, end_x, end_y, end_z,
    input  ready
  );

  modport sink (
    input  valid, normal_x, normal_y, normal_z,
    input  plane_point_x, plane_point_y, plane_point_z,
    input  start_x, start_y, start_z, end_x, end_y, end_z,
    output ready
  );
endinterface

// File: src/spc_out_if.sv
interface spc_out_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    seg_class;
  logic signed [COORD_WIDTH-1:0] t_value;
  logic signed [COORD_WIDTH-1:0] cross_x;
  logic signed [COORD_WIDTH-1:0] cross_y;
  logic signed [COORD_WIDTH-1:0] cross_z;

  modport source (
    output valid, seg_class, t_value, cross_x, cross_y, cross_z,
    input  ready
  );

  modport sink (
    input  valid, seg_class, t_value, cross_x, cross_y, cross_z,
    output ready
  );
endinterface

// File: src/segment_plane_classifier_core.sv
// Channel   Dir  Beat contents
// seg_in    in   plane normal (Q1.14), plane point, segment start and end (Q16.16)
// seg_out   out  seg_class, t_value, cross_x/y/z (Q16.16, saturated)
// APB       in   zero_epsilon at byte address 0
//
// One item is accepted every cycle while seg_in.ready is high. A result passes through two
// front stages, the queue, COORD_WIDTH + 1 divider stages for t (one quotient bit per stage
// after the first), then six stages of multiply and saturate and the output register.
// Reset is synchronous and clears every valid bit; there is no clearing pass.
// When seg_out stalls, the back pipeline holds; the front keeps accepting beats until
// the queue between them fills, then seg_in.ready drops.
module segment_plane_classifier_core #(
  parameter int COORD_WIDTH      = 32,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  spc_in_if.sink      seg_in,
  spc_out_if.source   seg_out
);

  localparam int ITEM_W = spc_pkg::item_bits(COORD_WIDTH);

  // Configuration register, written only at its own address.
  logic [spc_pkg::EPS_W-1:0] zero_epsilon;
  logic                      cfg_write;

  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = 32'(zero_epsilon);

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_epsilon <= spc_pkg::EPS_RESET;
    end else if (cfg_write && (paddr == spc_pkg::ADDR_ZERO_EPSILON)) begin
      zero_epsilon <= pwdata[spc_pkg::EPS_W-1:0];
    end
  end

  logic              push_valid;
  logic              push_ready;
  logic [ITEM_W-1:0] push_item;
  logic              pop_valid;
  logic              pop_ready;
  logic [ITEM_W-1:0] pop_item;

  spc_front #(
    .COORD_WIDTH      (COORD_WIDTH),
    .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .seg_in       (seg_in),
    .zero_epsilon (zero_epsilon),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_item    (push_item)
  );

  spc_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (spc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_item)
  );

  spc_back #(
    .COORD_WIDTH      (COORD_WIDTH),
    .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (pop_valid),
    .q_pop   (pop_ready),
    .q_item  (pop_item),
    .seg_out (seg_out)
  );

endmodule

// File: src/spc_front.sv
module spc_front #(
  parameter int COORD_WIDTH      = 32,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                                          clk,
  input  logic                                          rst,
  spc_in_if.sink                                        seg_in,
  input  logic [spc_pkg::EPS_W-1:0]                     zero_epsilon,
  output logic                                          push_valid,
  input  logic                                          push_ready,
  output logic [spc_pkg::item_bits(COORD_WIDTH)-1:0]    push_item
);

  localparam int W  = COORD_WIDTH;
  localparam int NW = spc_pkg::NORMAL_W;
  localparam int DW = W + spc_pkg::DOT_GUARD;
  localparam int PW = W + 1 + NW;
  localparam int EW = DW + 32;

  typedef struct packed {
    logic                  skip;
    logic [1:0]            cls;
    logic                  neg;
    logic [DW-1:0]         amag;
    logic [DW-1:0]         dmag;
    logic [2:0][NW-1:0]    n;
    logic [2:0][W-1:0]     p;
    logic [2:0][W-1:0]     a;
    logic [2:0][W:0]       d;
  } item_t;

  logic adv;

  // Input fields as small arrays, one entry per axis.
  logic signed [NW-1:0] in_n [3];
  logic signed [W-1:0]  in_p [3];
  logic signed [W-1:0]  in_a [3];
  logic signed [W-1:0]  in_b [3];

  assign in_n[0] = seg_in.normal_x;
  assign in_n[1] = seg_in.normal_y;
  assign in_n[2] = seg_in.normal_z;
  assign in_p[0] = seg_in.plane_point_x;
  assign in_p[1] = seg_in.plane_point_y;
  assign in_p[2] = seg_in.plane_point_z;
  assign in_a[0] = seg_in.start_x;
  assign in_a[1] = seg_in.start_y;
  assign in_a[2] = seg_in.start_z;
  assign in_b[0] = seg_in.end_x;
  assign in_b[1] = seg_in.end_y;
  assign in_b[2] = seg_in.end_z;

  // Stage 1: direction and offset vectors, and their products with the normal.
  logic signed [W:0]    c_d  [3];
  logic signed [W:0]    c_v  [3];
  logic signed [PW-1:0] c_pd [3];
  logic signed [PW-1:0] c_pv [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_d[i]  = (W+1)'(in_b[i]) - (W+1)'(in_a[i]);
      c_v[i]  = (W+1)'(in_a[i]) - (W+1)'(in_p[i]);
      c_pd[i] = PW'(in_n[i]) * PW'(c_d[i]);
      c_pv[i] = PW'(in_n[i]) * PW'(c_v[i]);
    end
  end

  logic                 s1_valid;
  logic signed [NW-1:0] s1_n  [3];
  logic signed [W-1:0]  s1_p  [3];
  logic signed [W-1:0]  s1_a  [3];
  logic signed [W:0]    s1_d  [3];
  logic signed [PW-1:0] s1_pd [3];
  logic signed [PW-1:0] s1_pv [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= seg_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s1_n[i]  <= in_n[i];
        s1_p[i]  <= in_p[i];
        s1_a[i]  <= in_a[i];
        s1_d[i]  <= c_d[i];
        s1_pd[i] <= c_pd[i];
        s1_pv[i] <= c_pv[i];
      end
    end
  end

  // Stage 2: dot products, near-zero tests and the division operands.
  logic signed [DW-1:0] denom;
  logic signed [DW-1:0] num;
  logic [DW-1:0]        dmag;
  logic [DW-1:0]        amag;
  logic [EW-1:0]        eps_sh;
  logic                 denom_zero;
  logic                 num_zero;
  item_t                it_next;

  always_comb begin
    denom      = DW'(s1_pd[0]) + DW'(s1_pd[1]) + DW'(s1_pd[2]);
    num        = DW'(s1_pv[0]) + DW'(s1_pv[1]) + DW'(s1_pv[2]);
    dmag       = denom[DW-1] ? -denom : denom;
    amag       = num[DW-1] ? -num : num;
    eps_sh     = EW'(zero_epsilon) << NORMAL_FRAC_BITS;
    denom_zero = (denom == '0) || (EW'(dmag) < eps_sh);
    num_zero   = (num == '0) || (EW'(amag) < eps_sh);

    it_next.skip = denom_zero;
    it_next.cls  = num_zero ? spc_pkg::CLS_COPLANAR : spc_pkg::CLS_PARALLEL;
    it_next.neg  = (num != '0) && (num[DW-1] == denom[DW-1]);
    it_next.amag = amag;
    it_next.dmag = dmag;
    for (int i = 0; i < 3; i++) begin
      it_next.n[i] = s1_n[i];
      it_next.p[i] = s1_p[i];
      it_next.a[i] = s1_a[i];
      it_next.d[i] = s1_d[i];
    end
  end

  logic  s2_valid;
  item_t s2_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_item <= it_next;
    end
  end

  // The front moves whenever its last stage is empty or the queue takes a beat.
  assign adv          = !s2_valid || push_ready;
  assign seg_in.ready = adv;
  assign push_valid   = s2_valid;
  assign push_item    = s2_item;

endmodule

// File: src/spc_queue.sv
module spc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = slots[rptr];

  // Pointers wrap at the depth; the count tracks occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_data;
    end
  end

endmodule

// File: src/spc_back.sv
module spc_back #(
  parameter int COORD_WIDTH      = 32,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       q_valid,
  output logic                                       q_pop,
  input  logic [spc_pkg::item_bits(COORD_WIDTH)-1:0] q_item,
  spc_out_if.source                                  seg_out
);

  localparam int W  = COORD_WIDTH;
  localparam int NW = spc_pkg::NORMAL_W;
  localparam int CF = spc_pkg::COORD_FRAC;
  localparam int DW = W + spc_pkg::DOT_GUARD;
  localparam int PW = W + 1 + NW;
  localparam int SW = 2 * W - 14;
  localparam int CW = NW + DW;
  localparam int XW = 2 * W + 40;

  localparam logic [W-1:0] T_LIM = {1'b1, {(W-1){1'b0}}};
  localparam logic [W+1:0] T_ONE = (W+2)'(1) << CF;

  typedef struct packed {
    logic                  skip;
    logic [1:0]            cls;
    logic                  neg;
    logic [DW-1:0]         amag;
    logic [DW-1:0]         dmag;
    logic [2:0][NW-1:0]    n;
    logic [2:0][W-1:0]     p;
    logic [2:0][W-1:0]     a;
    logic [2:0][W:0]       d;
  } item_t;

  typedef struct packed {
    item_t         it;
    logic [DW-1:0] rem;
    logic [W-1:0]  quo;
    logic          ovf;
  } dstg_t;

  // Saturate a wide signed value to the coordinate range.
  function automatic logic signed [W-1:0] sat_w(input logic signed [XW-1:0] x);
    logic signed [XW-1:0] hi;
    logic signed [XW-1:0] lo;
    hi = XW'({1'b0, {(W-1){1'b1}}});
    lo = -hi - XW'(1);
    if (x > hi) begin
      return hi[W-1:0];
    end else if (x < lo) begin
      return lo[W-1:0];
    end
    return x[W-1:0];
  endfunction

  logic  adv;
  logic  o_v;
  item_t qi;

  // The whole back pipeline moves unless a finished result waits to be taken.
  assign adv   = !o_v || seg_out.ready;
  assign q_pop = adv && q_valid;
  assign qi    = item_t'(q_item);

  // Divider: one quotient bit per stage after the first, restoring, remainder starts from the top bits.
  dstg_t      dv [W+1];
  logic [W:0] dv_v;
  dstg_t      d0_next;

  always_comb begin
    d0_next.it  = qi;
    d0_next.rem = DW'(qi.amag >> (W - CF));
    d0_next.quo = '0;
    d0_next.ovf = (DW'(qi.amag >> (W - CF)) >= qi.dmag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v <= '0;
    end else if (adv) begin
      dv_v <= {dv_v[W-1:0], q_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv[0] <= d0_next;
    end
  end

  for (genvar k = 1; k <= W; k++) begin : g_div
    localparam int J = W - k;
    logic        nbit;
    logic [DW:0] trial;
    logic        ge;

    if (J >= CF) begin : g_bit
      assign nbit = dv[k-1].it.amag[J-CF];
    end else begin : g_zero
      assign nbit = 1'b0;
    end

    assign trial = {dv[k-1].rem, nbit};
    assign ge    = (trial >= {1'b0, dv[k-1].it.dmag});

    always_ff @(posedge clk) begin
      if (adv) begin
        dv[k].it  <= dv[k-1].it;
        dv[k].ovf <= dv[k-1].ovf;
        dv[k].rem <= ge ? DW'(trial - {1'b0, dv[k-1].it.dmag}) : DW'(trial);
        dv[k].quo <= {dv[k-1].quo[W-2:0], ge};
      end
    end
  end

  // Stage T: saturated t, its class, and magnitudes for the scaling multiply.
  dstg_t                dl;
  logic                 big;
  logic [W-1:0]         tm;
  logic [W-1:0]         tv;
  logic [1:0]           tcls;
  logic [W:0]           dm_c [3];

  assign dl = dv[W];

  always_comb begin
    big = dl.ovf || dl.quo[W-1];
    if (dl.it.neg) begin
      tm = big ? T_LIM : dl.quo;
    end else begin
      tm = big ? (T_LIM - W'(1)) : dl.quo;
    end
    if (dl.it.skip) begin
      tm = '0;
    end
    tv = dl.it.neg ? (~tm + W'(1)) : tm;
    if (dl.it.skip) begin
      tcls = dl.it.cls;
    end else if (!tv[W-1] && ({2'b00, tv} <= T_ONE)) begin
      tcls = spc_pkg::CLS_ON_SEG;
    end else begin
      tcls = spc_pkg::CLS_OFF_SEG;
    end
    for (int i = 0; i < 3; i++) begin
      dm_c[i] = dl.it.d[i][W] ? -dl.it.d[i] : dl.it.d[i];
    end
  end

  logic                 t_v;
  logic [1:0]           t_cls;
  logic [W-1:0]         t_val;
  logic [W-1:0]         t_mag;
  logic [W:0]           t_dm [3];
  logic                 t_dneg [3];
  logic signed [W-1:0]  t_a [3];
  logic signed [W-1:0]  t_p [3];
  logic signed [NW-1:0] t_n [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      t_cls <= tcls;
      t_val <= tv;
      t_mag <= tm;
      for (int i = 0; i < 3; i++) begin
        t_dm[i]   <= dm_c[i];
        t_dneg[i] <= dl.it.d[i][W];
        t_a[i]    <= dl.it.a[i];
        t_p[i]    <= dl.it.p[i];
        t_n[i]    <= dl.it.n[i];
      end
    end
  end

  // Stage M1: D * t, truncated toward zero to Q16.16.
  logic [2*W:0]         prod [3];
  logic [SW-1:0]        pmag [3];
  logic signed [SW-1:0] s_c  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i] = (2*W+1)'(t_dm[i]) * (2*W+1)'(t_mag);
      pmag[i] = SW'(prod[i] >> CF);
      s_c[i]  = (t_dneg[i] != t_val[W-1]) ? -$signed(pmag[i]) : $signed(pmag[i]);
    end
  end

  logic                 m1_v;
  logic [1:0]           m1_cls;
  logic [W-1:0]         m1_t;
  logic signed [SW-1:0] m1_s [3];
  logic signed [W-1:0]  m1_a [3];
  logic signed [W-1:0]  m1_p [3];
  logic signed [NW-1:0] m1_n [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_cls <= t_cls;
      m1_t   <= t_val;
      for (int i = 0; i < 3; i++) begin
        m1_s[i] <= s_c[i];
        m1_a[i] <= t_a[i];
        m1_p[i] <= t_p[i];
        m1_n[i] <= t_n[i];
      end
    end
  end

  // Stage M2: intersection point A + D * t, saturated.
  logic                 m2_v;
  logic [1:0]           m2_cls;
  logic [W-1:0]         m2_t;
  logic signed [W-1:0]  m2_i [3];
  logic signed [W-1:0]  m2_p [3];
  logic signed [NW-1:0] m2_n [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_cls <= m1_cls;
      m2_t   <= m1_t;
      for (int i = 0; i < 3; i++) begin
        m2_i[i] <= sat_w(XW'(m1_a[i]) + XW'(m1_s[i]));
        m2_p[i] <= m1_p[i];
        m2_n[i] <= m1_n[i];
      end
    end
  end

  // Stage M3: products of the normal with I - P.
  logic signed [W:0]    v_c  [3];
  logic signed [PW-1:0] pv_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v_c[i]  = (W+1)'(m2_i[i]) - (W+1)'(m2_p[i]);
      pv_c[i] = PW'(m2_n[i]) * PW'(v_c[i]);
    end
  end

  logic                 m3_v;
  logic [1:0]           m3_cls;
  logic [W-1:0]         m3_t;
  logic signed [W-1:0]  m3_i  [3];
  logic signed [NW-1:0] m3_n  [3];
  logic signed [PW-1:0] m3_pv [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      m3_cls <= m2_cls;
      m3_t   <= m2_t;
      for (int i = 0; i < 3; i++) begin
        m3_i[i]  <= m2_i[i];
        m3_n[i]  <= m2_n[i];
        m3_pv[i] <= pv_c[i];
      end
    end
  end

  // Stage M4: signed distance of I, floored to Q16.16.
  logic signed [DW-1:0] di_c;

  assign di_c = DW'(m3_pv[0]) + DW'(m3_pv[1]) + DW'(m3_pv[2]);

  logic                 m4_v;
  logic [1:0]           m4_cls;
  logic [W-1:0]         m4_t;
  logic signed [W-1:0]  m4_i [3];
  logic signed [NW-1:0] m4_n [3];
  logic signed [DW-1:0] m4_d;

  always_ff @(posedge clk) begin
    if (adv) begin
      m4_cls <= m3_cls;
      m4_t   <= m3_t;
      m4_d   <= di_c >>> NORMAL_FRAC_BITS;
      for (int i = 0; i < 3; i++) begin
        m4_i[i] <= m3_i[i];
        m4_n[i] <= m3_n[i];
      end
    end
  end

  // Stage M5: correction n * d, floored to Q16.16.
  logic                 m5_v;
  logic [1:0]           m5_cls;
  logic [W-1:0]         m5_t;
  logic signed [W-1:0]  m5_i [3];
  logic signed [CW-1:0] m5_c [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      m5_cls <= m4_cls;
      m5_t   <= m4_t;
      for (int i = 0; i < 3; i++) begin
        m5_i[i] <= m4_i[i];
        m5_c[i] <= (CW'(m4_n[i]) * CW'(m4_d)) >>> NORMAL_FRAC_BITS;
      end
    end
  end

  // Output register: nudged point, zeroed for the parallel and coplanar classes.
  logic                skip5;
  logic [1:0]          o_cls;
  logic [W-1:0]        o_t;
  logic signed [W-1:0] o_x [3];

  assign skip5 = (m5_cls == spc_pkg::CLS_COPLANAR) || (m5_cls == spc_pkg::CLS_PARALLEL);

  always_ff @(posedge clk) begin
    if (adv) begin
      o_cls <= m5_cls;
      o_t   <= m5_t;
      for (int i = 0; i < 3; i++) begin
        o_x[i] <= skip5 ? '0 : sat_w(XW'(m5_i[i]) - XW'(m5_c[i]));
      end
    end
  end

  // Valid bits of the stages after the divider.
  always_ff @(posedge clk) begin
    if (rst) begin
      t_v  <= 1'b0;
      m1_v <= 1'b0;
      m2_v <= 1'b0;
      m3_v <= 1'b0;
      m4_v <= 1'b0;
      m5_v <= 1'b0;
      o_v  <= 1'b0;
    end else if (adv) begin
      t_v  <= dv_v[W];
      m1_v <= t_v;
      m2_v <= m1_v;
      m3_v <= m2_v;
      m4_v <= m3_v;
      m5_v <= m4_v;
      o_v  <= m5_v;
    end
  end

  assign seg_out.valid     = o_v;
  assign seg_out.seg_class = o_cls;
  assign seg_out.t_value   = o_t;
  assign seg_out.cross_x   = o_x[0];
  assign seg_out.cross_y   = o_x[1];
  assign seg_out.cross_z   = o_x[2];

endmodule

// File: src/spc_checker.sv
module spc_checker #(
  parameter int W = 32
) (
  input logic         clk,
  input logic         rst,
  input logic         out_valid,
  input logic         out_ready,
  input logic [1:0]   seg_class,
  input logic [W-1:0] t_value,
  input logic [W-1:0] cross_x,
  input logic [W-1:0] cross_y,
  input logic [W-1:0] cross_z
);

  localparam logic [W+1:0] T_ONE = (W+2)'(1) << spc_pkg::COORD_FRAC;

  // A stalled result beat stays valid and keeps its class, t and cross_x.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(seg_class) && $stable(t_value)
      && $stable(cross_x))
    else $error("result beat changed while stalled");

  // No crossing means t and the point are zero.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (seg_class == spc_pkg::CLS_COPLANAR || seg_class == spc_pkg::CLS_PARALLEL)
      |-> t_value == '0 && cross_x == '0 && cross_y == '0 && cross_z == '0)
    else $error("non-crossing result carries a nonzero t or point");

  // A crossing on the segment has t in the unit range.
  a_on: assert property (@(posedge clk) disable iff (rst)
    out_valid && seg_class == spc_pkg::CLS_ON_SEG
      |-> !t_value[W-1] && ((W+2)'(t_value) <= T_ONE))
    else $error("on-segment class with t outside the unit range");

  // A crossing off the segment has t outside the unit range.
  a_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && seg_class == spc_pkg::CLS_OFF_SEG
      |-> t_value[W-1] || ((W+2)'(t_value) > T_ONE))
    else $error("off-segment class with t inside the unit range");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat offered right after reset");

endmodule

bind segment_plane_classifier_core spc_checker #(.W(COORD_WIDTH)) u_spc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (seg_out.valid),
  .out_ready (seg_out.ready),
  .seg_class (seg_out.seg_class),
  .t_value   (seg_out.t_value),
  .cross_x   (seg_out.cross_x),
  .cross_y   (seg_out.cross_y),
  .cross_z   (seg_out.cross_z)
);
